// File: hdl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, character codes and helpers for the escaped string decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 9;

    // Hard cap on data bytes kept per string
    localparam logic [LEN_W-1:0] MAX_BYTES = 9'd256;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Characters recognized after a backslash
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
    localparam logic [CHAR_W-1:0] CH_E      = 8'h65;
    localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_7      = 8'h37;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF     = 8'h46;

    // Decoded values of the named escapes
    localparam logic [CHAR_W-1:0] BYTE_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] BYTE_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] BYTE_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] BYTE_ESC = 8'h1B;

    // One result beat
    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] data_byte;
        logic [LEN_W-1:0]  total_length;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Hex digit value of a character, ok low if not a hex digit
    function automatic hex_t hex_digit(input logic [CHAR_W-1:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            h.val = 4'(c - CH_0);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            h.val = 4'(c - CH_LA + 8'd10);
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            h.val = 4'(c - CH_UA + 8'd10);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_octal(input logic [CHAR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

endpackage

// File: hdl/esd_if.sv
// ----------------------------------------------------------------------------
// esd_if
// Valid/ready channels of the escaped string decoder: characters in,
// results out, and the max_length register write port.
// ----------------------------------------------------------------------------
interface esd_char_if
    import esd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              is_final;

    modport source (output valid, output char_in, output is_final, input ready);
    modport sink   (input valid, input char_in, input is_final, output ready);
endinterface

interface esd_result_if
    import esd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [CHAR_W-1:0] data_byte;
    logic [LEN_W-1:0]  total_length;

    modport source (output valid, output kind, output data_byte, output total_length,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input total_length,
                    output ready);
endinterface

interface esd_cfg_if
    import esd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/escaped_string_decoder.sv
// ----------------------------------------------------------------------------
// escaped_string_decoder
// Decodes a C-style escaped string, one character per beat, into data bytes
// followed by an end beat that carries the string length.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              beat accepted when
//  chars     in   char_in[7:0], is_final               valid && ready
//  results   out  kind, data_byte[7:0], total_length   valid && ready
//  cfg       in   data[8:0] -> max_length              valid && ready (always)
//
//  A character is captured into an input register, decoded into a
//  registered bundle of 0..3 result beats, and the bundle drains one beat per
//  cycle while results are ready. The next character is decoded once the
//  bundle is empty or its last beat is taken; the single result port sets
//  the pace. Reset returns the decoder to plain text, clears the count and
//  sets max_length to 256. Backpressure on results stalls the bundle and
//  then the input register; nothing is dropped.
// ----------------------------------------------------------------------------
module escaped_string_decoder
    import esd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    esd_char_if.sink       chars,
    esd_result_if.source   results,
    esd_cfg_if.sink        cfg
);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_HEX0,
        MODE_HEX1,
        MODE_OCT1,
        MODE_OCT2
    } mode_t;

    // Control state
    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] pend_reg, pend_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] max_len_reg;
    logic             in_valid_reg;
    logic             bun_valid_reg;
    logic [1:0]       bun_cnt_reg;
    logic [1:0]       bun_idx_reg;

    // Payload
    logic [CHAR_W-1:0] char_reg;
    logic              fin_reg;
    result_t           bun_reg [3];

    // Decode outputs
    result_t          slot_next [3];
    logic [1:0]       n_next;

    logic bun_last;
    logic bun_free;
    logic advance;
    logic in_fire;

    // Handshakes
    assign bun_last  = (bun_idx_reg == bun_cnt_reg - 2'd1);
    assign bun_free  = !bun_valid_reg || (results.ready && bun_last);
    assign advance   = in_valid_reg && bun_free;
    assign chars.ready = !in_valid_reg || advance;
    assign in_fire   = chars.valid && chars.ready;
    assign cfg.ready = 1'b1;

    // Output beat select
    assign results.valid        = bun_valid_reg;
    assign results.kind         = bun_reg[bun_idx_reg].kind;
    assign results.data_byte    = bun_reg[bun_idx_reg].data_byte;
    assign results.total_length = bun_reg[bun_idx_reg].total_length;

    // Decode one character into up to three result beats
    always_comb
    begin
        logic              want  [3];
        logic [CHAR_W-1:0] cand  [3];
        logic [LEN_W-1:0]  limit;
        logic [LEN_W-1:0]  cnt;
        logic [1:0]        n;
        hex_t              h;
        logic              oct;

        want[0] = 1'b0;
        want[1] = 1'b0;
        want[2] = 1'b0;
        cand[0] = '0;
        cand[1] = '0;
        cand[2] = '0;
        mode_next = MODE_NORMAL;
        pend_next = pend_reg;
        h   = hex_digit(char_reg);
        oct = is_octal(char_reg);

        // Slot 0: flushed digit value, slot 1: byte from this character
        unique case (mode_reg)
            MODE_ESC:
            begin
                priority if (char_reg == CH_BSLASH)
                begin
                    want[1] = 1'b1; cand[1] = CH_BSLASH;
                end
                else if (char_reg == CH_QUOTE)
                begin
                    want[1] = 1'b1; cand[1] = CH_QUOTE;
                end
                else if (char_reg == CH_N)
                begin
                    want[1] = 1'b1; cand[1] = BYTE_LF;
                end
                else if (char_reg == CH_R)
                begin
                    want[1] = 1'b1; cand[1] = BYTE_CR;
                end
                else if (char_reg == CH_T)
                begin
                    want[1] = 1'b1; cand[1] = BYTE_TAB;
                end
                else if (char_reg == CH_E)
                begin
                    want[1] = 1'b1; cand[1] = BYTE_ESC;
                end
                else if (char_reg == CH_X)
                begin
                    mode_next = MODE_HEX0;
                end
                else if (oct)
                begin
                    pend_next = LEN_W'(char_reg - CH_0);
                    mode_next = MODE_OCT1;
                end
                else
                begin
                    // unknown escape: backslash dropped, char taken as text
                    want[1] = 1'b1; cand[1] = char_reg;
                end
            end
            MODE_HEX0:
            begin
                if (h.ok)
                begin
                    pend_next = LEN_W'(h.val);
                    mode_next = MODE_HEX1;
                end
                else if (char_reg == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    want[1] = 1'b1; cand[1] = char_reg;
                end
            end
            MODE_HEX1:
            begin
                if (h.ok)
                begin
                    want[1] = 1'b1; cand[1] = {pend_reg[3:0], h.val};
                end
                else
                begin
                    want[0] = 1'b1; cand[0] = pend_reg[CHAR_W-1:0];
                    if (char_reg == CH_BSLASH)
                        mode_next = MODE_ESC;
                    else
                    begin
                        want[1] = 1'b1; cand[1] = char_reg;
                    end
                end
                pend_next = '0;
            end
            MODE_OCT1:
            begin
                if (oct)
                begin
                    pend_next = {pend_reg[5:0], char_reg[2:0]};
                    mode_next = MODE_OCT2;
                end
                else
                begin
                    want[0] = 1'b1; cand[0] = pend_reg[CHAR_W-1:0];
                    pend_next = '0;
                    if (char_reg == CH_BSLASH)
                        mode_next = MODE_ESC;
                    else
                    begin
                        want[1] = 1'b1; cand[1] = char_reg;
                    end
                end
            end
            MODE_OCT2:
            begin
                if (oct)
                begin
                    want[1] = 1'b1; cand[1] = {pend_reg[4:0], char_reg[2:0]};
                end
                else
                begin
                    want[0] = 1'b1; cand[0] = pend_reg[CHAR_W-1:0];
                    if (char_reg == CH_BSLASH)
                        mode_next = MODE_ESC;
                    else
                    begin
                        want[1] = 1'b1; cand[1] = char_reg;
                    end
                end
                pend_next = '0;
            end
            default:
            begin
                if (char_reg == CH_BSLASH)
                    mode_next = MODE_ESC;
                else
                begin
                    want[1] = 1'b1; cand[1] = char_reg;
                end
            end
        endcase

        // Slot 2: digits still pending at end of string
        if (fin_reg && (mode_next == MODE_HEX1 || mode_next == MODE_OCT1 ||
                        mode_next == MODE_OCT2))
        begin
            want[2] = 1'b1;
            cand[2] = pend_next[CHAR_W-1:0];
        end

        // Pack candidates that fit under the length limit
        limit = (max_len_reg < MAX_BYTES) ? max_len_reg : MAX_BYTES;
        cnt   = count_reg;
        n     = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            slot_next[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (want[i] && (cnt < limit))
            begin
                slot_next[n] = '{kind: KIND_DATA, data_byte: cand[i], total_length: '0};
                n   = n + 2'd1;
                cnt = cnt + 9'd1;
            end
        end

        // End beat and clear for the next string
        count_next = cnt;
        if (fin_reg)
        begin
            slot_next[n] = '{kind: KIND_END, data_byte: '0, total_length: cnt};
            n          = n + 2'd1;
            count_next = '0;
            mode_next  = MODE_NORMAL;
            pend_next  = '0;
        end
        n_next = n;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            pend_reg      <= '0;
            count_reg     <= '0;
            max_len_reg   <= MAX_BYTES;
            in_valid_reg  <= 1'b0;
            bun_valid_reg <= 1'b0;
            bun_cnt_reg   <= 2'd0;
            bun_idx_reg   <= 2'd0;
        end
        else
        begin
            if (cfg.valid)
                max_len_reg <= cfg.data;

            // input register
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            // decode and bundle
            if (advance)
            begin
                mode_reg      <= mode_next;
                pend_reg      <= pend_next;
                count_reg     <= count_next;
                bun_valid_reg <= (n_next != 2'd0);
                bun_cnt_reg   <= n_next;
                bun_idx_reg   <= 2'd0;
            end
            else if (bun_valid_reg && results.ready)
            begin
                if (bun_last)
                    bun_valid_reg <= 1'b0;
                else
                    bun_idx_reg <= bun_idx_reg + 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            char_reg <= chars.char_in;
            fin_reg  <= chars.is_final;
        end
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bun_reg[i] <= slot_next[i];
            end
        end
    end

endmodule

// File: verif/escaped_string_decoder_tb.sv
// ----------------------------------------------------------------------------
// escaped_string_decoder_tb
// Self-checking bench for the escaped string decoder. A short table of
// directed characters comes first, then random strings built half from
// well-formed escapes, under several max_length settings. Every result beat
// is checked against an in-bench decoder model or, for some directed rows,
// hand-written results. Both channels idle at random, and once the result
// side holds off long enough to back up the input.
module escaped_string_decoder_tb
    import esd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_CHARS  = 40;

    // Decoder states of the model
    typedef enum logic [2:0] {
        ST_TEXT,
        ST_ESC,
        ST_HEX0,
        ST_HEX1,
        ST_OCT1,
        ST_OCT2
    } dec_state_t;

    // One directed character, with optional hand-written results
    typedef struct {
        logic [CHAR_W-1:0] c;
        logic              fin;
        int                n_typed;
        result_t           r0;
        result_t           r1;
    } dir_row_t;

    logic clk;
    logic rst_n;

    esd_char_if   chars_if ();
    esd_result_if res_if ();
    esd_cfg_if    cfg_if ();

    escaped_string_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (res_if),
        .cfg     (cfg_if)
    );

    // Model state
    dec_state_t       p_state;
    logic [LEN_W-1:0] p_pend;
    logic [LEN_W-1:0] p_count;
    logic [LEN_W-1:0] p_maxlen;

    result_t    expected_beats[$];
    result_t    step_beats[$];
    result_t    typed_beats[$];
    dir_row_t   dir_rows[$];
    logic [7:0] str_chars[$];

    int  n_errors   = 0;
    int  n_chars    = 0;
    int  n_strings  = 0;
    int  n_beats    = 0;
    int  n_settings = 0;
    int  n_holds    = 0;
    int  n_cycles   = 0;
    int  src_burst  = 0;
    int  snk_burst  = 0;
    bit  hold_req   = 1'b0;

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic result_t make_beat(input logic k, input logic [7:0] b,
                                          input logic [LEN_W-1:0] len);
        result_t r;
        r.kind         = k;
        r.data_byte    = b;
        r.total_length = len;
        return r;
    endfunction

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            v = c[3:0];
            return 1'b1;
        end
        if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))
        begin
            v = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic oct_char(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

    // Emit a data byte unless the string is already at its limit
    function automatic void keep_byte(input logic [7:0] b);
        logic [LEN_W-1:0] limit;
        limit = (p_maxlen < MAX_BYTES) ? p_maxlen : MAX_BYTES;
        if (p_count < limit)
        begin
            step_beats.push_back(make_beat(KIND_DATA, b, '0));
            p_count = p_count + 1'b1;
        end
    endfunction

    function automatic void take_plain(input logic [7:0] c);
        if (c == CH_BSLASH)
            p_state = ST_ESC;
        else
            keep_byte(c);
    endfunction

    // One character into the model; its beats land in step_beats
    function automatic void predict_char(input logic [7:0] c, input logic fin);
        dec_state_t st;
        logic [3:0] nib;
        logic       is_hex;
        logic       is_oct;
        st      = p_state;
        p_state = ST_TEXT;
        is_hex  = hex_nibble(c, nib);
        is_oct  = oct_char(c);
        step_beats.delete();
        case (st)
            ST_ESC:
            begin
                case (c)
                    CH_BSLASH: keep_byte(CH_BSLASH);
                    CH_QUOTE:  keep_byte(CH_QUOTE);
                    CH_N:      keep_byte(BYTE_LF);
                    CH_R:      keep_byte(BYTE_CR);
                    CH_T:      keep_byte(BYTE_TAB);
                    CH_E:      keep_byte(BYTE_ESC);
                    CH_X:      p_state = ST_HEX0;
                    default:
                    begin
                        if (is_oct)
                        begin
                            p_pend  = {6'd0, c[2:0]};
                            p_state = ST_OCT1;
                        end
                        else
                        begin
                            take_plain(c);
                        end
                    end
                endcase
            end
            ST_HEX0:
            begin
                if (is_hex)
                begin
                    p_pend  = {5'd0, nib};
                    p_state = ST_HEX1;
                end
                else
                begin
                    take_plain(c);
                end
            end
            ST_HEX1:
            begin
                if (is_hex)
                begin
                    keep_byte({p_pend[3:0], nib});
                end
                else
                begin
                    keep_byte(p_pend[7:0]);
                    take_plain(c);
                end
                p_pend = '0;
            end
            ST_OCT1:
            begin
                if (is_oct)
                begin
                    p_pend  = {p_pend[5:0], c[2:0]};
                    p_state = ST_OCT2;
                end
                else
                begin
                    keep_byte(p_pend[7:0]);
                    p_pend = '0;
                    take_plain(c);
                end
            end
            ST_OCT2:
            begin
                if (is_oct)
                begin
                    keep_byte({p_pend[4:0], c[2:0]});
                end
                else
                begin
                    keep_byte(p_pend[7:0]);
                    take_plain(c);
                end
                p_pend = '0;
            end
            default:
            begin
                take_plain(c);
            end
        endcase

        // End of string: flush a held digit value, then the length beat
        if (fin)
        begin
            if (p_state == ST_HEX1 || p_state == ST_OCT1 || p_state == ST_OCT2)
                keep_byte(p_pend[7:0]);
            step_beats.push_back(make_beat(KIND_END, 8'd0, p_count));
            p_state = ST_TEXT;
            p_pend  = '0;
            p_count = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Idle cycles before a beat; now and then a run of back-to-back beats
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return CH_0 + 8'(v);
        if ($urandom_range(0, 1) == 1)
            return CH_LA + 8'(v - 10);
        return CH_UA + 8'(v - 10);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic fin, input bit typed);
        int gap;
        gap = draw_gap(src_burst);
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid    <= 1'b1;
        chars_if.char_in  <= c;
        chars_if.is_final <= fin;
        @(posedge clk);
        while (!chars_if.ready) @(posedge clk);

        // Beat taken: model it and queue what should come out
        predict_char(c, fin);
        if (typed)
        begin
            foreach (typed_beats[i])
                expected_beats.push_back(typed_beats[i]);
        end
        else
        begin
            foreach (step_beats[i])
                expected_beats.push_back(step_beats[i]);
        end
        n_chars++;
        if (fin)
            n_strings++;
    endtask

    // Wait until every expected beat is out and the pipe has settled
    task automatic wait_idle();
        chars_if.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] v);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        p_maxlen = v;
        n_settings++;
    endtask

    // Random string: half well-formed escapes, plus plain text, noise and cut escapes
    task automatic build_string();
        int         n_tok;
        int         pick;
        logic [3:0] nib;
        logic [7:0] c;
        str_chars.delete();
        n_tok = $urandom_range(1, 8);
        repeat (n_tok)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                do c = 8'($urandom_range(1, 255)); while (c == CH_BSLASH);
                str_chars.push_back(c);
            end
            else if (pick < 45)
            begin
                str_chars.push_back(CH_BSLASH);
                case ($urandom_range(0, 5))
                    0: str_chars.push_back(CH_BSLASH);
                    1: str_chars.push_back(CH_QUOTE);
                    2: str_chars.push_back(CH_N);
                    3: str_chars.push_back(CH_R);
                    4: str_chars.push_back(CH_T);
                    default: str_chars.push_back(CH_E);
                endcase
            end
            else if (pick < 60)
            begin
                str_chars.push_back(CH_BSLASH);
                str_chars.push_back(CH_X);
                str_chars.push_back(rand_hex_char());
                if ($urandom_range(0, 1) == 1)
                    str_chars.push_back(rand_hex_char());
            end
            else if (pick < 75)
            begin
                str_chars.push_back(CH_BSLASH);
                repeat ($urandom_range(1, 3))
                    str_chars.push_back(CH_0 + 8'($urandom_range(0, 7)));
            end
            else if (pick < 82)
            begin
                // any escape letter, mostly unknown ones
                str_chars.push_back(CH_BSLASH);
                str_chars.push_back(8'($urandom_range(1, 255)));
            end
            else if (pick < 88)
            begin
                // \x followed by something that is not a hex digit
                str_chars.push_back(CH_BSLASH);
                str_chars.push_back(CH_X);
                do c = 8'($urandom_range(1, 255)); while (hex_nibble(c, nib));
                str_chars.push_back(c);
            end
            else if (pick < 94)
            begin
                str_chars.push_back(8'($urandom_range(1, 255)));
            end
            else
            begin
                // cut-off escape, completed by whatever follows
                str_chars.push_back(CH_BSLASH);
                if ($urandom_range(0, 1) == 1)
                    str_chars.push_back(CH_X);
            end
        end
    endtask

    task automatic add_row(input logic [7:0] c, input logic fin, input int n_typed,
                           input result_t r0, input result_t r1);
        dir_row_t row;
        row.c       = c;
        row.fin     = fin;
        row.n_typed = n_typed;
        row.r0      = r0;
        row.r1      = r1;
        dir_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold-off on request, checking
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int      gap;
        result_t got;
        result_t want;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(snk_burst);
            if (hold_req)
            begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
                n_holds++;
            end
            if (gap > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);

            got = {res_if.kind, res_if.data_byte, res_if.total_length};
            n_beats++;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d byte 0x%02h len %0d",
                       got.kind, got.data_byte, got.total_length);
                n_errors++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    n_errors++;
                end
                if (got.data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected 0x%02h, got 0x%02h",
                           want.data_byte, got.data_byte);
                    n_errors++;
                end
                if (got.total_length !== want.total_length)
                begin
                    $error("total_length: expected %0d, got %0d",
                           want.total_length, got.total_length);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (n_cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            n_cycles++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("escaped_string_decoder_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic [LEN_W-1:0] settings[$];
        result_t          none;
        int               phase_chars;
        int               wait_cycles;

        none = make_beat(KIND_DATA, 8'd0, '0);
        chars_if.valid    <= 1'b0;
        chars_if.char_in  <= '0;
        chars_if.is_final <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.data       <= '0;

        p_state  = ST_TEXT;
        p_pend   = '0;
        p_count  = '0;
        p_maxlen = MAX_BYTES;

        // Directed table, max_length at its reset value
        add_row("A", 1'b1, 2, make_beat(KIND_DATA, 8'h41, '0), make_beat(KIND_END, 8'd0, 9'd1));
        // character zero passes as a plain byte
        add_row(8'h00, 1'b1, 2, make_beat(KIND_DATA, 8'h00, '0),
                make_beat(KIND_END, 8'd0, 9'd1));
        add_row(8'hFF, 1'b1, 2, make_beat(KIND_DATA, 8'hFF, '0),
                make_beat(KIND_END, 8'd0, 9'd1));
        add_row(CH_BSLASH, 1'b0, 0, none, none);
        add_row(CH_N,      1'b0, 0, none, none);
        add_row(CH_BSLASH, 1'b0, 0, none, none);
        add_row(CH_T,      1'b0, 0, none, none);
        add_row(CH_BSLASH, 1'b0, 0, none, none);
        add_row(CH_E,      1'b0, 0, none, none);
        // two hex digits, top value
        add_row(CH_BSLASH, 1'b0, 0, none, none);
        add_row(CH_X,      1'b0, 0, none, none);
        add_row("F",       1'b0, 0, none, none);
        add_row("f",       1'b0, 0, none, none);
        // \x with no digit drops both, g is plain
        add_row(CH_BSLASH, 1'b0, 0, none, none);
        add_row(CH_X,      1'b0, 0, none, none);
        add_row("g",       1'b0, 0, none, none);
        // three octal digits wrap to the low 8 bits
        add_row(CH_BSLASH, 1'b0, 0, none, none);
        add_row(CH_7,      1'b0, 0, none, none);
        add_row(CH_7,      1'b0, 0, none, none);
        add_row(CH_7,      1'b0, 0, none, none);
        // unknown escape drops the backslash
        add_row(CH_BSLASH, 1'b0, 0, none, none);
        add_row("q",       1'b0, 0, none, none);
        // octal digit held when the string ends
        add_row(CH_BSLASH, 1'b0, 0, none, none);
        add_row("1",       1'b1, 0, none, none);
        // lone backslash as the last character: empty string
        add_row(CH_BSLASH, 1'b1, 1, make_beat(KIND_END, 8'd0, 9'd0), none);

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            typed_beats.delete();
            if (dir_rows[i].n_typed > 0)
                typed_beats.push_back(dir_rows[i].r0);
            if (dir_rows[i].n_typed > 1)
                typed_beats.push_back(dir_rows[i].r1);
            send_char(dir_rows[i].c, dir_rows[i].fin, dir_rows[i].n_typed > 0);
        end

        // Random phases over several length limits
        settings.push_back(MAX_BYTES);
        settings.push_back(9'd1);
        settings.push_back(9'd0);
        settings.push_back(9'd3);
        settings.push_back(LEN_W'($urandom_range(1, 256)));
        settings.push_back(9'd2);
        settings.push_back(LEN_W'($urandom_range(4, 20)));
        settings.push_back(MAX_BYTES);

        foreach (settings[s])
        begin
            write_max_length(settings[s]);
            // first phase: stall results long enough to back up the input
            if (s == 0)
                hold_req = 1'b1;
            phase_chars = 0;
            while (phase_chars < PHASE_CHARS)
            begin
                build_string();
                foreach (str_chars[i])
                    send_char(str_chars[i], i == str_chars.size() - 1, 1'b0);
                phase_chars += str_chars.size();
            end
        end

        // Drain, then let the pipe settle
        chars_if.valid <= 1'b0;
        wait_cycles = 0;
        while (expected_beats.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (expected_beats.size() != 0)
        begin
            $error("%0d expected result beats never arrived", expected_beats.size());
            n_errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d characters in %0d strings, %0d result beats checked,",
                 n_chars, n_strings, n_beats);
        $display("under %0d max_length writes and %0d long result stall(s).",
                 n_settings, n_holds);
        if (n_errors == 0)
            $display("escaped_string_decoder_tb: PASS");
        else
            $display("escaped_string_decoder_tb: FAIL");
        $finish;
    end

endmodule
